// ===== hw/rtl/snh_pkg.sv =====
// ----------------------------------------------------------------------------
// snh_pkg: shared codes for the stable Neo-Hookean stress/energy unit
// Configuration register indexes and the dimension code.
// ----------------------------------------------------------------------------
`default_nettype none

package snh_pkg;

  typedef enum logic [1:0] {
    CFG_SHEAR_MODULUS = 2'd0,
    CFG_BULK_MODULUS  = 2'd1,
    CFG_MODULUS_RATIO = 2'd2,
    CFG_DIMENSION     = 2'd3
  } cfg_idx_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam int DIM_BITS       = 2;

  // Only this code selects planar mode; every other code runs 3D.
  localparam logic [DIM_BITS-1:0] DIM_CODE_2D = 2'd2;
  localparam logic [DIM_BITS-1:0] DIM_CODE_3D = 2'd3;

  // Register stages from input register to output register.
  localparam int NUM_STAGES = 12;

endpackage

`default_nettype wire

// ===== hw/rtl/snh_if.sv =====
// ----------------------------------------------------------------------------
// snh_in_if / snh_out_if: valid/ready channels of the stress/energy unit
// Input carries F and the energy weight, output carries P and the energy.
// ----------------------------------------------------------------------------
`default_nettype none

interface snh_in_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] f00, f01, f02;
  logic signed [WORD_BITS-1:0] f10, f11, f12;
  logic signed [WORD_BITS-1:0] f20, f21, f22;
  logic signed [WORD_BITS-1:0] energy_weight;

  modport source (
    output valid, f00, f01, f02, f10, f11, f12, f20, f21, f22, energy_weight,
    input  ready
  );
  modport sink (
    input  valid, f00, f01, f02, f10, f11, f12, f20, f21, f22, energy_weight,
    output ready
  );
endinterface

interface snh_out_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] p00, p01, p02;
  logic signed [WORD_BITS-1:0] p10, p11, p12;
  logic signed [WORD_BITS-1:0] p20, p21, p22;
  logic signed [WORD_BITS-1:0] strain_energy;

  modport source (
    output valid, p00, p01, p02, p10, p11, p12, p20, p21, p22, strain_energy,
    input  ready
  );
  modport sink (
    input  valid, p00, p01, p02, p10, p11, p12, p20, p21, p22, strain_energy,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/stable_neo_hookean_stress_energy.sv =====
// ----------------------------------------------------------------------------
// stable_neo_hookean_stress_energy: first Piola stress and weighted energy
// Twelve-stage pipeline, one deformation gradient per cycle unless the output stalls, Q-format math.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  (sink)  : one beat = F (f00..f22, row-major) plus energy_weight.
//   out_chan (source): one beat = P (p00..p22) plus strain_energy, in order.
//   cfg_*            : write-only register port, cfg_we strobes cfg_data into
//                      register cfg_index (shear, bulk, ratio, dimension).
//                      Write it only while the pipeline is empty.
// Throughput: one beat per cycle while out_chan is not stalled. Twelve register
//   stages lie between input and output: the chain of multiply stages
//   (cofactors, determinant, lambda*Jm, s*C, 0.5*e, w*e), each product
//   registered raw and rounded/saturated in the following stage.
// Stall: the whole pipe freezes while out_chan.valid is high and
//   out_chan.ready is low; in_chan.ready drops in the same cycle, so no beat
//   is lost or repeated. Bubbles fill in while the output is taken.
// Reset (rst_n low, synchronous): pipeline emptied, mu = lambda = ratio = 1.0,
//   dimension = 3D.
// 2D mode: the third row and column of F are ignored and P reads zero there.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_neo_hookean_stress_energy
  import snh_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  snh_in_if.sink                         in_chan,
  snh_out_if.source                      out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [WORD_BITS-1:0]      cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int W2 = 2 * WORD_BITS;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // Saturate a double-width value into one word.
  function automatic logic signed [W-1:0] sat_wide(input logic signed [W2-1:0] v);
    logic signed [W2-1:0] hi_lim;
    logic signed [W2-1:0] lo_lim;
    hi_lim = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    lo_lim = ~hi_lim;
    if (v > hi_lim) return WMAX;
    else if (v < lo_lim) return WMIN;
    else return v[W-1:0];
  endfunction

  localparam logic signed [W2-1:0] ONE_WIDE  = W2'(1) << FRAC_BITS;
  localparam logic signed [W2-1:0] BIAS      = W2'(1) << (FRAC_BITS - 1);
  localparam logic signed [W-1:0]  Q_ONE     = sat_wide(ONE_WIDE);
  localparam logic signed [W-1:0]  Q_HALF    = sat_wide(BIAS);
  localparam logic signed [W-1:0]  Q_DIM2    = sat_wide(W2'(2) << FRAC_BITS);
  localparam logic signed [W-1:0]  Q_DIM3    = sat_wide(W2'(3) << FRAC_BITS);

  // Round half up, drop the fraction, saturate.
  function automatic logic signed [W-1:0] rnd(input logic signed [W2-1:0] p);
    logic signed [W2-1:0] t;
    t = p + BIAS;
    return sat_wide(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [W2-1:0] mulw(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W2-1:0] xa;
    logic signed [W2-1:0] xb;
    xa = a;
    xb = b;
    return xa * xb;
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    else return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    else return s[W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [W-1:0]   mu_r, lambda_r, ratio_r;
  logic [DIM_BITS-1:0]   dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r     <= Q_ONE;
      lambda_r <= Q_ONE;
      ratio_r  <= Q_ONE;
      dim_r    <= DIM_CODE_3D;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SHEAR_MODULUS: mu_r     <= cfg_data;
        CFG_BULK_MODULUS:  lambda_r <= cfg_data;
        CFG_MODULUS_RATIO: ratio_r  <= cfg_data;
        CFG_DIMENSION:     dim_r    <= cfg_data[DIM_BITS-1:0];
        default:           dim_r    <= dim_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: advance all stages together unless the output is held
  // --------------------------------------------------------------------------
  logic                  adv;
  logic [NUM_STAGES-1:0] v_r;

  assign adv           = !v_r[NUM_STAGES-1] || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NUM_STAGES-2:0], in_chan.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: mask F for 2D, form all raw cofactor, square and mu*F products
  // --------------------------------------------------------------------------
  logic                   in_2d;
  logic signed [W-1:0]    fin [3][3];
  logic signed [W2-1:0]   pa_nxt [3][3], pb_nxt [3][3];
  logic signed [W2-1:0]   ff_nxt [3][3], muf_nxt [3][3];

  assign in_2d = (dim_r == DIM_CODE_2D);

  always_comb begin
    fin[0][0] = in_chan.f00; fin[0][1] = in_chan.f01; fin[0][2] = in_chan.f02;
    fin[1][0] = in_chan.f10; fin[1][1] = in_chan.f11; fin[1][2] = in_chan.f12;
    fin[2][0] = in_chan.f20; fin[2][1] = in_chan.f21; fin[2][2] = in_chan.f22;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (in_2d && (i == 2 || j == 2)) fin[i][j] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_nxt[i][j]  = mulw(fin[(i == 2) ? 0 : i + 1][(j == 2) ? 0 : j + 1],
                             fin[(i == 0) ? 2 : i - 1][(j == 0) ? 2 : j - 1]);
        pb_nxt[i][j]  = mulw(fin[(i == 0) ? 2 : i - 1][(j == 2) ? 0 : j + 1],
                             fin[(i == 2) ? 0 : i + 1][(j == 0) ? 2 : j - 1]);
        ff_nxt[i][j]  = mulw(fin[i][j], fin[i][j]);
        muf_nxt[i][j] = mulw(mu_r, fin[i][j]);
      end
    end
  end

  logic signed [W2-1:0] s1_pa_r [3][3], s1_pb_r [3][3];
  logic signed [W2-1:0] s1_ff_r [3][3], s1_muf_r [3][3];
  logic signed [W-1:0]  s1_f_r [3][3];
  logic signed [W-1:0]  s1_w_r;
  logic                 s1_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pa_r  <= pa_nxt;
      s1_pb_r  <= pb_nxt;
      s1_ff_r  <= ff_nxt;
      s1_muf_r <= muf_nxt;
      s1_f_r   <= fin;
      s1_w_r   <= in_chan.energy_weight;
      s1_2d_r  <= in_2d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cofactors, 2D determinant, first half of |F|^2, rounded mu*F
  // --------------------------------------------------------------------------
  logic signed [W-1:0] c3_nxt [3][3], c_nxt [3][3];
  logic signed [W-1:0] ffr_nxt [3][3], mufr_nxt [3][3];
  logic signed [W-1:0] icp_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c3_nxt[i][j]   = ssub(rnd(s1_pa_r[i][j]), rnd(s1_pb_r[i][j]));
        ffr_nxt[i][j]  = rnd(s1_ff_r[i][j]);
        mufr_nxt[i][j] = rnd(s1_muf_r[i][j]);
        c_nxt[i][j]    = c3_nxt[i][j];
        if (s1_2d_r) c_nxt[i][j] = '0;
      end
    end
    if (s1_2d_r) begin
      c_nxt[0][0] = s1_f_r[1][1];
      c_nxt[0][1] = ssub('0, s1_f_r[1][0]);
      c_nxt[1][0] = ssub('0, s1_f_r[0][1]);
      c_nxt[1][1] = s1_f_r[0][0];
    end
    icp_nxt = sadd(sadd(sadd(sadd(ffr_nxt[0][0], ffr_nxt[0][1]), ffr_nxt[0][2]),
                        ffr_nxt[1][0]), ffr_nxt[1][1]);
  end

  logic signed [W-1:0] s2_c_r [3][3], s2_ffr_r [3][3], s2_muf_r [3][3];
  logic signed [W-1:0] s2_fc0_r [3];
  logic signed [W-1:0] s2_det2_r, s2_icp_r, s2_w_r;
  logic                s2_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c_r    <= c_nxt;
      s2_ffr_r  <= ffr_nxt;
      s2_muf_r  <= mufr_nxt;
      for (int i = 0; i < 3; i++) s2_fc0_r[i] <= s1_f_r[i][0];
      s2_det2_r <= c3_nxt[2][2];   // f00*f11 - f10*f01
      s2_icp_r  <= icp_nxt;
      s2_w_r    <= s1_w_r;
      s2_2d_r   <= s1_2d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: raw determinant products, finish |F|^2
  // --------------------------------------------------------------------------
  logic signed [W2-1:0] s3_dp_r [3];
  logic signed [W-1:0]  s3_c_r [3][3], s3_muf_r [3][3];
  logic signed [W-1:0]  s3_det2_r, s3_ic_r, s3_w_r;
  logic                 s3_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s3_dp_r[i] <= mulw(s2_fc0_r[i], s2_c_r[i][0]);
      s3_ic_r   <= sadd(sadd(sadd(sadd(s2_icp_r, s2_ffr_r[1][2]), s2_ffr_r[2][0]),
                             s2_ffr_r[2][1]), s2_ffr_r[2][2]);
      s3_c_r    <= s2_c_r;
      s3_muf_r  <= s2_muf_r;
      s3_det2_r <= s2_det2_r;
      s3_w_r    <= s2_w_r;
      s3_2d_r   <= s2_2d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: determinant, Jm = J - 1 - ratio, |F|^2 - dim
  // --------------------------------------------------------------------------
  logic signed [W-1:0] det_nxt;

  assign det_nxt = s3_2d_r ? s3_det2_r
                           : sadd(sadd(rnd(s3_dp_r[0]), rnd(s3_dp_r[1])), rnd(s3_dp_r[2]));

  logic signed [W-1:0] s4_jm_r, s4_icm_r, s4_w_r;
  logic signed [W-1:0] s4_c_r [3][3], s4_muf_r [3][3];
  logic                s4_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_jm_r  <= ssub(ssub(det_nxt, Q_ONE), ratio_r);
      s4_icm_r <= ssub(s3_ic_r, s3_2d_r ? Q_DIM2 : Q_DIM3);
      s4_c_r   <= s3_c_r;
      s4_muf_r <= s3_muf_r;
      s4_w_r   <= s3_w_r;
      s4_2d_r  <= s3_2d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: raw lambda*Jm and mu*(|F|^2 - dim)
  // --------------------------------------------------------------------------
  logic signed [W2-1:0] s5_sp_r, s5_mp_r;
  logic signed [W-1:0]  s5_jm_r, s5_w_r;
  logic signed [W-1:0]  s5_c_r [3][3], s5_muf_r [3][3];
  logic                 s5_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sp_r  <= mulw(lambda_r, s4_jm_r);
      s5_mp_r  <= mulw(mu_r, s4_icm_r);
      s5_jm_r  <= s4_jm_r;
      s5_c_r   <= s4_c_r;
      s5_muf_r <= s4_muf_r;
      s5_w_r   <= s4_w_r;
      s5_2d_r  <= s4_2d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: round s = lambda*Jm and the shear energy term
  // --------------------------------------------------------------------------
  logic signed [W-1:0] s6_s_r, s6_muic_r, s6_jm_r, s6_w_r;
  logic signed [W-1:0] s6_c_r [3][3], s6_muf_r [3][3];
  logic                s6_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_s_r    <= rnd(s5_sp_r);
      s6_muic_r <= rnd(s5_mp_r);
      s6_jm_r   <= s5_jm_r;
      s6_c_r    <= s5_c_r;
      s6_muf_r  <= s5_muf_r;
      s6_w_r    <= s5_w_r;
      s6_2d_r   <= s5_2d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: raw s*C and s*Jm
  // --------------------------------------------------------------------------
  logic signed [W2-1:0] s7_scp_r [3][3];
  logic signed [W2-1:0] s7_sjp_r;
  logic signed [W-1:0]  s7_muic_r, s7_w_r;
  logic signed [W-1:0]  s7_muf_r [3][3];
  logic                 s7_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) s7_scp_r[i][j] <= mulw(s6_s_r, s6_c_r[i][j]);
      end
      s7_sjp_r  <= mulw(s6_s_r, s6_jm_r);
      s7_muic_r <= s6_muic_r;
      s7_muf_r  <= s6_muf_r;
      s7_w_r    <= s6_w_r;
      s7_2d_r   <= s6_2d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: stress P = mu*F + s*C, unscaled energy
  // --------------------------------------------------------------------------
  logic signed [W-1:0] s8_p_r [3][3];
  logic signed [W-1:0] s8_e1_r, s8_w_r;
  logic                s8_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s8_p_r[i][j] <= sadd(s7_muf_r[i][j], rnd(s7_scp_r[i][j]));
        end
      end
      s8_e1_r <= sadd(s7_muic_r, rnd(s7_sjp_r));
      s8_w_r  <= s7_w_r;
      s8_2d_r <= s7_2d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 9 to 12: halve, then weight the energy; carry P alongside
  // --------------------------------------------------------------------------
  logic signed [W2-1:0] s9_hp_r, s11_wp_r;
  logic signed [W-1:0]  s9_w_r, s10_e2_r, s10_w_r, s12_e_r;
  logic signed [W-1:0]  s9_p_r [3][3], s10_p_r [3][3], s11_p_r [3][3], s12_p_r [3][3];
  logic                 s9_2d_r, s10_2d_r, s11_2d_r, s12_2d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_hp_r  <= mulw(Q_HALF, s8_e1_r);
      s9_p_r   <= s8_p_r;
      s9_w_r   <= s8_w_r;
      s9_2d_r  <= s8_2d_r;

      s10_e2_r <= rnd(s9_hp_r);
      s10_p_r  <= s9_p_r;
      s10_w_r  <= s9_w_r;
      s10_2d_r <= s9_2d_r;

      s11_wp_r <= mulw(s10_w_r, s10_e2_r);
      s11_p_r  <= s10_p_r;
      s11_2d_r <= s10_2d_r;

      s12_e_r  <= rnd(s11_wp_r);
      s12_p_r  <= s11_p_r;
      s12_2d_r <= s11_2d_r;
    end
  end

  assign out_chan.valid         = v_r[NUM_STAGES-1];
  assign out_chan.p00           = s12_p_r[0][0];
  assign out_chan.p01           = s12_p_r[0][1];
  assign out_chan.p02           = s12_p_r[0][2];
  assign out_chan.p10           = s12_p_r[1][0];
  assign out_chan.p11           = s12_p_r[1][1];
  assign out_chan.p12           = s12_p_r[1][2];
  assign out_chan.p20           = s12_p_r[2][0];
  assign out_chan.p21           = s12_p_r[2][1];
  assign out_chan.p22           = s12_p_r[2][2];
  assign out_chan.strain_energy = s12_e_r;

`ifndef ASSERT_OFF
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("pipeline holds a beat after reset");

  a_valid_advances: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[0] |=> v_r[1])
    else $error("beat lost between first and second stage");

  a_stall_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("valid bits moved during an output stall");

  a_planar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && s12_2d_r |-> out_chan.p02 == '0 && out_chan.p12 == '0 &&
      out_chan.p20 == '0 && out_chan.p21 == '0 && out_chan.p22 == '0)
    else $error("2D beat has nonzero third row or column");
`endif

endmodule

`default_nettype wire
